/* rtl/pbse_pkg.sv */
// Package with the types, codes and encoding functions of the protobuf scalar field encoder.
package pbse_pkg;

  typedef enum logic [2:0] {
    CMD_BOOL    = 3'd0,
    CMD_INT     = 3'd1,
    CMD_UINT    = 3'd2,
    CMD_SINT    = 3'd3,
    CMD_FIXED32 = 3'd4,
    CMD_FIXED64 = 3'd5,
    CMD_FLOAT   = 3'd6
  } cmd_t;

  typedef enum logic {
    PH_TAG = 1'b0,
    PH_VAL = 1'b1
  } phase_t;

  localparam logic [2:0] WT_VARINT  = 3'd0;
  localparam logic [2:0] WT_FIXED64 = 3'd1;
  localparam logic [2:0] WT_FIXED32 = 3'd5;

  localparam int unsigned CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] REG_BYTE_LIMIT  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SIZING_ONLY = CFG_IDX_W'(1);

  localparam logic [31:0] BYTE_LIMIT_RESET = 32'hFFFF_FFFF;

  typedef struct packed {
    logic        restart;
    logic        has_parts;
    logic [31:0] tag_word;
    logic [2:0]  tag_len;
    logic [63:0] val_word;
    logic        val_varint;
    logic [3:0]  val_len;
  } job_t;

  typedef struct packed {
    logic [31:0] byte_limit;
    logic        sizing_only;
  } cfg_t;

  function automatic logic [3:0] varint_len64(input logic [63:0] v);
    logic [3:0] n;
    n = 4'd1;
    for (int k = 1; k < 10; k++) begin
      if ((v >> (7 * k)) != 64'd0) begin
        n = n + 4'd1;
      end
    end
    return n;
  endfunction

  function automatic logic [2:0] varint_len32(input logic [31:0] v);
    logic [2:0] n;
    n = 3'd1;
    for (int k = 1; k < 5; k++) begin
      if ((v >> (7 * k)) != 32'd0) begin
        n = n + 3'd1;
      end
    end
    return n;
  endfunction

  function automatic logic [7:0] varint_byte(input logic [63:0] v, input logic [3:0] idx,
                                             input logic [3:0] len);
    logic [6:0] grp;
    grp = 7'(v >> (7 * idx));
    return {(idx != len - 4'd1), grp};
  endfunction

  function automatic logic [63:0] float_to_double(input logic [31:0] f);
    logic [7:0]  e;
    logic [22:0] m;
    logic [10:0] de;
    logic [22:0] dm;
    logic [4:0]  pos;
    logic [4:0]  lz;
    logic [23:0] sh;
    e   = f[30:23];
    m   = f[22:0];
    pos = 5'd0;
    for (int i = 0; i < 23; i++) begin
      if (m[i]) begin
        pos = 5'(i);
      end
    end
    lz = 5'd22 - pos;
    sh = {1'b0, m} << (lz + 5'd1);
    if (e == 8'hFF) begin
      de = 11'h7FF;
      dm = m;
    end else if (e == 8'h00) begin
      if (m == 23'd0) begin
        de = 11'd0;
        dm = 23'd0;
      end else begin
        de = 11'd896 - 11'(lz);
        dm = sh[22:0];
      end
    end else begin
      de = 11'(e) + 11'd896;
      dm = m;
    end
    return {f[31], de, dm, 29'd0};
  endfunction

endpackage

/* rtl/pbse_if.sv */
// Channel interfaces for items, results and configuration writes.
interface pbse_item_if;
  logic        valid;
  logic        ready;
  logic        restart;
  logic [2:0]  cmd;
  logic [28:0] field_id;
  logic [63:0] value;
  modport source (output valid, restart, cmd, field_id, value, input ready);
  modport sink (input valid, restart, cmd, field_id, value, output ready);
endinterface

interface pbse_result_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        byte_valid;
  logic        last;
  logic        stream_full;
  logic [31:0] total_bytes;
  modport source (output valid, out_byte, byte_valid, last, stream_full, total_bytes,
                  input ready);
  modport sink (input valid, out_byte, byte_valid, last, stream_full, total_bytes,
                output ready);
endinterface

interface pbse_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* rtl/pbse_encode.sv */
// Input register and encoder that turns one field item into a tag and value job.
module pbse_encode (
  input  logic              clk,
  input  logic              rst,
  pbse_item_if.sink         items,
  input  logic              take,
  output logic              enc_valid,
  output pbse_pkg::job_t    enc_job
);
  import pbse_pkg::*;

  logic        s1_valid;
  logic        s1_restart;
  logic [2:0]  s1_cmd;
  logic [28:0] s1_fnum;
  logic [63:0] s1_value;

  logic [63:0] vword;
  logic [2:0]  wt;
  logic        varint;
  logic [3:0]  vlen;
  logic        known;

  assign items.ready = !s1_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (items.valid && items.ready) begin
      s1_valid <= 1'b1;
    end else if (take) begin
      s1_valid <= 1'b0;
    end
    if (items.valid && items.ready) begin
      s1_restart <= items.restart;
      s1_cmd     <= items.cmd;
      s1_fnum    <= items.field_id;
      s1_value   <= items.value;
    end
  end

  always_comb begin
    vword  = s1_value;
    wt     = WT_VARINT;
    varint = 1'b1;
    known  = 1'b1;
    unique case (cmd_t'(s1_cmd)) inside
      CMD_BOOL: begin
        vword = {63'd0, (s1_value != 64'd0)};
      end
      CMD_INT, CMD_UINT: begin
        vword = s1_value;
      end
      CMD_SINT: begin
        vword = {s1_value[62:0], 1'b0} ^ {64{s1_value[63]}};
      end
      CMD_FIXED32: begin
        vword  = {32'd0, s1_value[31:0]};
        wt     = WT_FIXED32;
        varint = 1'b0;
      end
      CMD_FIXED64: begin
        wt     = WT_FIXED64;
        varint = 1'b0;
      end
      CMD_FLOAT: begin
        vword  = float_to_double(s1_value[31:0]);
        wt     = WT_FIXED64;
        varint = 1'b0;
      end
      default: begin
        known = 1'b0;
      end
    endcase
    if (varint) begin
      vlen = varint_len64(vword);
    end else if (wt == WT_FIXED32) begin
      vlen = 4'd4;
    end else begin
      vlen = 4'd8;
    end
  end

  assign enc_valid          = s1_valid;
  assign enc_job.restart    = s1_restart;
  assign enc_job.has_parts  = known;
  assign enc_job.tag_word   = {s1_fnum, wt};
  assign enc_job.tag_len    = varint_len32({s1_fnum, wt});
  assign enc_job.val_word   = vword;
  assign enc_job.val_varint = varint;
  assign enc_job.val_len    = vlen;

endmodule

/* rtl/pbse_emit.sv */
// Byte sequencer that checks the limit, keeps the byte count and drives the result register.
module pbse_emit (
  input  logic              clk,
  input  logic              rst,
  input  pbse_pkg::cfg_t    cfg_regs,
  input  logic              enc_valid,
  input  pbse_pkg::job_t    enc_job,
  output logic              take,
  pbse_result_if.source     results
);
  import pbse_pkg::*;

  logic        job_valid;
  logic        job_valid_next;
  job_t        job;
  phase_t      phase;
  phase_t      phase_next;
  logic [3:0]  idx;
  logic [3:0]  idx_next;
  logic [31:0] byte_total;
  logic [31:0] byte_total_next;

  logic        out_valid;
  logic        out_valid_next;
  logic [7:0]  out_byte;
  logic        out_bvalid;
  logic        out_last;
  logic        out_full;
  logic [31:0] out_total;

  logic        step;
  logic        part_done;
  logic        item_done;
  logic [3:0]  cur_len;
  logic [7:0]  cur_byte;
  logic        over;
  logic        load;
  logic [7:0]  r_byte;
  logic        r_bvalid;
  logic        r_full;
  logic [31:0] r_total;

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid  <= 1'b0;
      phase      <= PH_TAG;
      idx        <= 4'd0;
      byte_total <= 32'd0;
      out_valid  <= 1'b0;
    end else begin
      job_valid  <= job_valid_next;
      phase      <= phase_next;
      idx        <= idx_next;
      byte_total <= byte_total_next;
      out_valid  <= out_valid_next;
    end
    if (load) begin
      job <= enc_job;
    end
    if (step) begin
      out_byte   <= r_byte;
      out_bvalid <= r_bvalid;
      out_last   <= item_done;
      out_full   <= r_full;
      out_total  <= r_total;
    end
  end

  always_comb begin
    step     = job_valid && (!out_valid || results.ready);
    cur_len  = (phase == PH_TAG) ? {1'b0, job.tag_len} : job.val_len;
    if (phase == PH_TAG) begin
      cur_byte = varint_byte({32'd0, job.tag_word}, idx, cur_len);
    end else if (job.val_varint) begin
      cur_byte = varint_byte(job.val_word, idx, cur_len);
    end else begin
      cur_byte = 8'(job.val_word >> {idx[2:0], 3'b000});
    end
    over = ({1'b0, byte_total} + 33'(cur_len)) > {1'b0, cfg_regs.byte_limit};

    r_byte    = 8'd0;
    r_bvalid  = 1'b0;
    r_full    = 1'b0;
    r_total   = byte_total;
    part_done = 1'b0;
    item_done = 1'b0;
    if (cfg_regs.sizing_only) begin
      r_total   = byte_total + 32'(cur_len);
      part_done = 1'b1;
    end else if (idx == 4'd0 && over) begin
      r_full    = 1'b1;
      item_done = 1'b1;
    end else begin
      r_byte    = cur_byte;
      r_bvalid  = 1'b1;
      r_total   = byte_total + 32'd1;
      part_done = (idx == cur_len - 4'd1);
    end
    if (part_done && phase == PH_VAL) begin
      item_done = 1'b1;
    end

    load = !job_valid || (step && item_done);
    take = load && enc_valid;

    job_valid_next  = job_valid;
    phase_next      = phase;
    idx_next        = idx;
    byte_total_next = byte_total;
    out_valid_next  = out_valid && !results.ready;
    if (step) begin
      out_valid_next  = 1'b1;
      byte_total_next = r_total;
      if (part_done) begin
        phase_next = PH_VAL;
        idx_next   = 4'd0;
      end else begin
        idx_next = idx + 4'd1;
      end
    end
    if (load) begin
      job_valid_next = enc_valid && enc_job.has_parts;
      phase_next     = PH_TAG;
      idx_next       = 4'd0;
      if (enc_valid && enc_job.restart) begin
        byte_total_next = 32'd0;
      end
    end
  end

  assign results.valid       = out_valid;
  assign results.out_byte    = out_byte;
  assign results.byte_valid  = out_bvalid;
  assign results.last        = out_last;
  assign results.stream_full = out_full;
  assign results.total_bytes = out_total;

endmodule

/* rtl/protobuf_scalar_field_encoder_core.sv */
// Top level of the protobuf scalar field encoder with the configuration registers.
//
//   Channel  Direction  Carries
//   items    in         restart, cmd, field_id, value
//   results  out        out_byte, byte_valid, last, stream_full, total_bytes
//   cfg      in         index, data (register write)
//
// An item passes an input register, is encoded, and then yields one result per cycle
// while the result register is not stalled, as the byte sequencer emits one byte a cycle.
// The next item waits in the input register while the current one is emitted.
// Reset is synchronous and clears the byte count and the limit to its maximum.
// A stalled result register holds its transfer and pauses the sequencer.
module protobuf_scalar_field_encoder_core (
  input  logic          clk,
  input  logic          rst,
  pbse_item_if.sink     items,
  pbse_result_if.source results,
  pbse_cfg_if.sink      cfg
);
  import pbse_pkg::*;

  cfg_t  cfg_regs;
  logic  enc_valid;
  job_t  enc_job;
  logic  take;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.byte_limit  <= BYTE_LIMIT_RESET;
      cfg_regs.sizing_only <= 1'b0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_BYTE_LIMIT:  cfg_regs.byte_limit  <= cfg.data;
        REG_SIZING_ONLY: cfg_regs.sizing_only <= cfg.data[0];
        default: ;
      endcase
    end
  end

  pbse_encode u_encode (
    .clk       (clk),
    .rst       (rst),
    .items     (items),
    .take      (take),
    .enc_valid (enc_valid),
    .enc_job   (enc_job)
  );

  pbse_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .cfg_regs  (cfg_regs),
    .enc_valid (enc_valid),
    .enc_job   (enc_job),
    .take      (take),
    .results   (results)
  );

endmodule
